@@ rtl/lcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg - shared types and constants of the LCS core
// Field widths, command codes and the result word of the cell unit.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int SYM_W  = 8;  // symbol byte
  localparam int KIND_W = 2;  // command code
  localparam int LEN_W  = 7;  // string length and table lengths

  // command codes of an input word
  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

  // result of the shared cell / compare unit
  typedef struct packed {
    logic             eq;   // symbols match
    logic             dir;  // 1 = step up (first string), 0 = step left
    logic [LEN_W-1:0] len;  // new table length of the cell
  } cell_res_t;

endpackage

@@ rtl/lcs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_in_if / lcs_out_if - valid/ready channels of the LCS core
// One word moves on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface lcs_in_if;
  logic                       valid;
  logic                       ready;
  logic [lcs_pkg::KIND_W-1:0] kind;
  logic [lcs_pkg::SYM_W-1:0]  symbol;

  modport source (output valid, kind, symbol, input ready);
  modport sink   (input valid, kind, symbol, output ready);
endinterface

interface lcs_out_if;
  logic                      valid;
  logic                      ready;
  logic [lcs_pkg::SYM_W-1:0] symbol_res;
  logic                      last;
  logic                      empty_res;
  logic                      truncated;

  modport source (output valid, symbol_res, last, empty_res, truncated, input ready);
  modport sink   (input valid, symbol_res, last, empty_res, truncated, output ready);
endinterface

@@ rtl/longest_common_subsequence_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_common_subsequence_core - LCS with traceback
// Loads two strings, then finds and streams their longest common subsequence.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : kind 0 appends symbol to the first string, kind 1 to the second,
//            kind 2 runs the search; kind 3 is ignored. Loads into a full
//            string are dropped and flag the next results as truncated.
//   out_ch : one word per subsequence symbol in forward order, last on the
//            final one; an empty subsequence gives one word with empty_res
//            and last set. Both strings clear once the last word is queued.
// Timing:
//   Load words are taken one per cycle outside a run. A run fills the
//   table with one shared cell unit, a memory read then a cell update per
//   cell, then walks back at most n+m steps (read, then step) and emits
//   each symbol (buffer read, then queued word). in_ch.ready is low for the
//   whole run. A finished word sits in the output register; the next load
//   can be taken while it waits. A stalled receiver holds the emission in place.
// Reset: synchronous, active low; clears lengths, flag and output valid.
//   String and table memories need no clearing.
// ----------------------------------------------------------------------------
module longest_common_subsequence_core #(
  parameter int MAX_LEN = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lcs_in_if.sink    in_ch,
  lcs_out_if.source out_ch
);

  localparam int IDX_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ROW_DEPTH  = 1 << (IDX_W + 1);
  localparam int CELL_DEPTH = 1 << (2 * IDX_W);
  localparam int SYM_W      = lcs_pkg::SYM_W;
  localparam int LEN_W      = lcs_pkg::LEN_W;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FRD   = 3'd1;  // fill: memory read
  localparam logic [2:0] ST_FCELL = 3'd2;  // fill: cell update
  localparam logic [2:0] ST_TRD   = 3'd3;  // traceback: memory read
  localparam logic [2:0] ST_TEVAL = 3'd4;  // traceback: step
  localparam logic [2:0] ST_ERD   = 3'd5;  // emit: buffer read
  localparam logic [2:0] ST_EOUT  = 3'd6;  // emit: queue word
  localparam logic [2:0] ST_EMPTY = 3'd7;  // emit: empty result

  logic [2:0]       state_r, state_nxt;
  logic [LEN_W-1:0] n_r, n_nxt, m_r, m_nxt, cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, e_r, e_nxt;
  logic [LEN_W-1:0] left_r, left_nxt, diag_r, diag_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_trunc_r, out_trunc_nxt;

  // memory ports
  logic [SYM_W-1:0] first_mem [MAX_LEN];
  logic [SYM_W-1:0] second_mem [MAX_LEN];
  logic [LEN_W-1:0] row_mem [ROW_DEPTH];
  logic             dir_mem [CELL_DEPTH];
  logic [SYM_W-1:0] rev_mem [MAX_LEN];
  logic [SYM_W-1:0] a_q, b_q, rev_q;
  logic [LEN_W-1:0] up_q;
  logic             dir_q;
  logic             load_a, load_b, cell_we, rev_we;

  logic             in_acc, out_free;
  logic             i_zero, j_zero;
  logic [IDX_W-1:0] n_last, m_last;
  logic [LEN_W-1:0] up_eff;
  lcs_pkg::cell_res_t cell_res;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign i_zero   = (i_r == '0);
  assign j_zero   = (j_r == '0);
  assign n_last   = IDX_W'(n_r - LEN_W'(1));
  assign m_last   = IDX_W'(m_r - LEN_W'(1));
  assign up_eff   = i_zero ? '0 : up_q;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.symbol_res = out_sym_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.empty_res  = out_empty_r;
  assign out_ch.truncated  = out_trunc_r;

  // shared cell / compare unit
  lcs_cell u_cell (
    .sym_a     (a_q),
    .sym_b     (b_q),
    .up        (up_eff),
    .left      (left_r),
    .diag      (diag_r),
    .first_row (i_zero),
    .first_col (j_zero),
    .res       (cell_res)
  );

  // string memories: load writes, registered reads at the walk indices
  always_ff @(posedge clk) begin
    if (load_a) begin
      first_mem[n_r[IDX_W-1:0]] <= in_ch.symbol;
    end
    a_q <= first_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      second_mem[m_r[IDX_W-1:0]] <= in_ch.symbol;
    end
    b_q <= second_mem[j_r];
  end

  // two length rows, ping-ponged on the row index
  always_ff @(posedge clk) begin
    if (cell_we) begin
      row_mem[{i_r[0], j_r}] <= cell_res.len;
    end
    up_q <= row_mem[{~i_r[0], j_r}];
  end

  // direction table, one bit per cell
  always_ff @(posedge clk) begin
    if (cell_we) begin
      dir_mem[{i_r, j_r}] <= cell_res.dir;
    end
    dir_q <= dir_mem[{i_r, j_r}];
  end

  // subsequence as found backward
  always_ff @(posedge clk) begin
    if (rev_we) begin
      rev_mem[cnt_r[IDX_W-1:0]] <= a_q;
    end
    rev_q <= rev_mem[e_r];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    ovf_nxt       = ovf_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    e_nxt         = e_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_trunc_nxt = out_trunc_r;
    load_a        = 1'b0;
    load_b        = 1'b0;
    cell_we       = 1'b0;
    rev_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.kind)
            lcs_pkg::KIND_LOAD_A: begin
              if (n_r < LEN_MAX) begin
                load_a = 1'b1;
                n_nxt  = n_r + LEN_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            lcs_pkg::KIND_LOAD_B: begin
              if (m_r < LEN_MAX) begin
                load_b = 1'b1;
                m_nxt  = m_r + LEN_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            lcs_pkg::KIND_RUN: begin
              cnt_nxt = '0;
              if (n_r == '0 || m_r == '0) begin
                state_nxt = ST_EMPTY;
              end else begin
                i_nxt     = '0;
                j_nxt     = '0;
                left_nxt  = '0;
                diag_nxt  = '0;
                state_nxt = ST_FRD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FRD: begin
        state_nxt = ST_FCELL;
      end

      // write one cell, carry left and diagonal along the row
      ST_FCELL: begin
        cell_we  = 1'b1;
        left_nxt = cell_res.len;
        diag_nxt = up_eff;
        if (j_r == m_last) begin
          if (i_r == n_last) begin
            j_nxt     = m_last;
            state_nxt = ST_TRD;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            j_nxt     = '0;
            left_nxt  = '0;
            diag_nxt  = '0;
            state_nxt = ST_FRD;
          end
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_FRD;
        end
      end

      ST_TRD: begin
        state_nxt = ST_TEVAL;
      end

      // one traceback step
      ST_TEVAL: begin
        state_nxt = ST_TRD;
        if (cell_res.eq) begin
          if (cnt_r < LEN_MAX) begin
            rev_we  = 1'b1;
            cnt_nxt = cnt_r + LEN_W'(1);
          end
          if (i_zero || j_zero) begin
            state_nxt = ST_ERD;
          end else begin
            i_nxt = i_r - IDX_W'(1);
            j_nxt = j_r - IDX_W'(1);
          end
        end else if (i_zero && j_zero) begin
          state_nxt = ST_ERD;
        end else if (dir_q) begin
          if (i_zero) begin
            state_nxt = ST_ERD;
          end else begin
            i_nxt = i_r - IDX_W'(1);
          end
        end else begin
          if (j_zero) begin
            state_nxt = ST_ERD;
          end else begin
            j_nxt = j_r - IDX_W'(1);
          end
        end
        // walk finished: start emission or report empty
        if (state_nxt == ST_ERD) begin
          if (cnt_nxt == '0) begin
            state_nxt = ST_EMPTY;
          end else begin
            e_nxt = IDX_W'(cnt_nxt - LEN_W'(1));
          end
        end
      end

      ST_ERD: begin
        state_nxt = ST_EOUT;
      end

      ST_EOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = rev_q;
          out_last_nxt  = (e_r == '0);
          out_empty_nxt = 1'b0;
          out_trunc_nxt = ovf_r;
          if (e_r == '0) begin
            n_nxt     = '0;
            m_nxt     = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            e_nxt     = e_r - IDX_W'(1);
            state_nxt = ST_ERD;
          end
        end
      end

      ST_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_empty_nxt = 1'b1;
          out_trunc_nxt = ovf_r;
          n_nxt         = '0;
          m_nxt         = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      m_r         <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      m_r         <= m_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    e_r         <= e_nxt;
    left_r      <= left_nxt;
    diag_r      <= diag_nxt;
    out_sym_r   <= out_sym_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  // checks
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r <= LEN_MAX) && (m_r <= LEN_MAX))
    else $error("string length beyond capacity");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r)
    else $error("empty result not marked last");

  a_run_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.kind == lcs_pkg::KIND_RUN) |=> (state_r != ST_IDLE))
    else $error("run word did not start the sequencer");

  a_fill_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FCELL) |-> (n_r != '0) && (m_r != '0))
    else $error("table fill with an empty string");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEVAL) |-> (cnt_r <= n_r) && (cnt_r <= m_r))
    else $error("subsequence longer than a string");

endmodule

@@ rtl/lcs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_cell - shared compare and update unit
// Compares two symbols and works out one table cell: its length and the
// traceback direction. Used for every cell fill and every traceback step.
// ----------------------------------------------------------------------------
module lcs_cell (
  input  logic [lcs_pkg::SYM_W-1:0] sym_a,
  input  logic [lcs_pkg::SYM_W-1:0] sym_b,
  input  logic [lcs_pkg::LEN_W-1:0] up,     // already zero on the first row
  input  logic [lcs_pkg::LEN_W-1:0] left,   // already zero on the first column
  input  logic [lcs_pkg::LEN_W-1:0] diag,   // already zero on first row/column
  input  logic                      first_row,
  input  logic                      first_col,
  output lcs_pkg::cell_res_t        res
);

  logic up_gt;

  assign up_gt = (up > left);

  // direction: left on the first row, up on the first column, else compare
  always_comb begin
    res.eq  = (sym_a == sym_b);
    if (first_row) begin
      res.dir = 1'b0;
    end else if (first_col) begin
      res.dir = 1'b1;
    end else begin
      res.dir = up_gt;
    end
    if (res.eq) begin
      res.len = diag + lcs_pkg::LEN_W'(1);
    end else begin
      res.len = up_gt ? up : left;
    end
  end

endmodule
